[rtl/fbt_pkg.sv]
// ----------------------------------------------------------------------------
// fbt_pkg
// Shared types and constants for the FEC block tracker.
// ----------------------------------------------------------------------------
package fbt_pkg;

   // sizing of the per-class table and header fields
   localparam int CLASS_BITS  = 3;
   localparam int BLOCK_BITS  = 5;
   localparam int MAX_K       = 64;
   localparam int NUM_CLASSES = 1 << CLASS_BITS;
   localparam int K_BITS      = 7;
   localparam int CNT_BITS    = 8;

   localparam logic [CNT_BITS-1:0] CNT_MAX   = '1;
   localparam logic [CNT_BITS-1:0] MAX_K_CNT = CNT_BITS'(MAX_K);

   // command codes on the result beat
   typedef enum logic [1:0] {
      CMD_IDLE    = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_DECODE  = 2'd2,
      CMD_BYPASS  = 2'd3
   } cmd_type;

   // one packet header
   typedef struct packed {
      logic                  bypass;
      logic [K_BITS-1:0]     code_k;
      logic [CNT_BITS-1:0]   packet_number;
      logic [BLOCK_BITS-1:0] block_number;
      logic [CLASS_BITS-1:0] class_sel;
   } hdr_type;

   // one per-class tracking entry
   typedef struct packed {
      logic [BLOCK_BITS-1:0] block;
      logic [CNT_BITS-1:0]   packet_total;
      logic [CNT_BITS-1:0]   data_total;
   } entry_type;

   // one result
   typedef struct packed {
      cmd_type             command;
      logic                drop;
      logic [CNT_BITS-1:0] released_count;
      logic                is_data;
   } result_type;

endpackage

[rtl/fbt_decide.sv]
// ----------------------------------------------------------------------------
// fbt_decide
// Per-header decision: drop, command and count, plus the updated class entry.
// ----------------------------------------------------------------------------
module fbt_decide
   import fbt_pkg::*;
(
   input  hdr_type    hdr,
   input  entry_type  entry,
   input  logic       data_wait,
   output result_type result,
   output entry_type  entry_next,
   output logic       entry_write
);

   logic [CNT_BITS-1:0] k;
   logic                is_data;
   logic                fresh;
   logic [CNT_BITS-1:0] ptot_inc;
   logic [CNT_BITS-1:0] dtot_inc;

   // effective code_k, clipped to the largest supported block
   always_comb begin
      if ({1'b0, hdr.code_k} > MAX_K_CNT) begin
         k = MAX_K_CNT;
      end else begin
         k = {1'b0, hdr.code_k};
      end
   end

   assign is_data = hdr.packet_number < k;
   assign fresh   = hdr.block_number != entry.block;

   // saturating counts for a packet in the current block
   assign ptot_inc = (entry.packet_total == CNT_MAX) ? CNT_MAX
                                                     : entry.packet_total + 1'b1;
   always_comb begin
      if (is_data && entry.data_total != CNT_MAX) begin
         dtot_inc = entry.data_total + 1'b1;
      end else begin
         dtot_inc = entry.data_total;
      end
   end

   // decision
   always_comb begin
      result.is_data = is_data;
      entry_next     = entry;
      entry_write    = 1'b0;

      if (hdr.bypass) begin
         result.command        = CMD_BYPASS;
         result.drop           = 1'b1;
         result.released_count = '0;
      end else if (fresh) begin
         // new block: report the old block and restart counting
         result.drop           = 1'b0;
         result.released_count = entry.packet_total;
         if (entry.packet_total < k) begin
            result.command = CMD_RELEASE;
         end else if (data_wait && entry.data_total < k) begin
            result.command = CMD_DECODE;
         end else begin
            result.command = CMD_IDLE;
         end
         entry_next.block        = hdr.block_number;
         entry_next.packet_total = CNT_BITS'(1);
         entry_next.data_total   = CNT_BITS'(is_data);
         entry_write             = 1'b1;
      end else begin
         // same block: drop once the block is complete
         result.drop = data_wait ? (entry.data_total >= k)
                                 : (entry.packet_total >= k);
         result.released_count = ptot_inc;
         if (data_wait) begin
            result.command = (dtot_inc == k && is_data) ? CMD_RELEASE : CMD_IDLE;
         end else if (ptot_inc != k) begin
            result.command = CMD_IDLE;
         end else begin
            result.command = (dtot_inc == k) ? CMD_RELEASE : CMD_DECODE;
         end
         entry_next.packet_total = ptot_inc;
         entry_next.data_total   = dtot_inc;
         entry_write             = 1'b1;
      end
   end

endmodule

[rtl/fec_block_tracker_top.sv]
// A request beat goes from the input register to the result register and out
// as its response beat. One header per cycle while rsp_stall is low; the class
// table is read and written in the decision stage, so back-to-back headers of
// one class see fresh counts. Reset (synchronous, active high) empties both
// pipeline registers, clears every class entry to zero and sets data-wait to 1.
// ----------------------------------------------------------------------------
// fec_block_tracker_top
// Per-class FEC block tracker: input register, decision stage, result register.
// ----------------------------------------------------------------------------
module fec_block_tracker_top
   import fbt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_bypass,
   input  logic [K_BITS-1:0]     req_code_k,
   input  logic [CNT_BITS-1:0]   req_packet_number,
   input  logic [BLOCK_BITS-1:0] req_block_number,
   input  logic [CLASS_BITS-1:0] req_class_sel,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_command,
   output logic                  rsp_drop,
   output logic [CNT_BITS-1:0]   rsp_released_count,
   output logic                  rsp_is_data
);

   logic       wait_ff;
   logic       s1_valid_ff;
   hdr_type    s1_hdr_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   entry_type  table_ff [NUM_CLASSES];

   logic       out_ready;
   entry_type  entry_cur;
   entry_type  entry_in;
   logic       entry_write;
   result_type result_in;

   // output register frees up when empty or taken
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_ready;

   assign entry_cur = table_ff[s1_hdr_ff.class_sel];

   fbt_decide u_decide (
      .hdr         (s1_hdr_ff),
      .entry       (entry_cur),
      .data_wait   (wait_ff),
      .result      (result_in),
      .entry_next  (entry_in),
      .entry_write (entry_write)
   );

   // control, config and class table
   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff      <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            table_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            wait_ff <= csr_wr_data;
         end
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff && entry_write) begin
               table_ff[s1_hdr_ff.class_sel] <= entry_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_hdr_ff.bypass        <= req_bypass;
         s1_hdr_ff.code_k        <= req_code_k;
         s1_hdr_ff.packet_number <= req_packet_number;
         s1_hdr_ff.block_number  <= req_block_number;
         s1_hdr_ff.class_sel     <= req_class_sel;
      end
      if (out_ready && s1_valid_ff) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command        = rsp_ff.command;
   assign rsp_drop           = rsp_ff.drop;
   assign rsp_released_count = rsp_ff.released_count;
   assign rsp_is_data        = rsp_ff.is_data;

endmodule

[rtl/fbt_checker.sv]
// ----------------------------------------------------------------------------
// fbt_checker
// Port-level checks for the FEC block tracker, bound to the top level.
// ----------------------------------------------------------------------------
module fbt_checker
   import fbt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [1:0]            rsp_command,
   input logic                  rsp_drop,
   input logic [CNT_BITS-1:0]   rsp_released_count,
   input logic                  rsp_is_data
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command) &&
         $stable(rsp_drop) && $stable(rsp_released_count) && $stable(rsp_is_data))
      else $error("response beat changed while stalled");

   // bypass beats are always dropped with a zero count
   a_bypass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_BYPASS |-> rsp_drop && rsp_released_count == '0)
      else $error("bypass beat with drop clear or nonzero count");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty output register never holds off the input
   a_no_false_stall: assert property (@(posedge clock)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output register is empty");

endmodule

bind fec_block_tracker_top fbt_checker u_fbt_checker (.*);
